[hw/rtl/gort_pkg.sv]
// Package for the grid occupancy ray traversal block: constants, codes and word types.
// No dependencies.
`default_nettype none
package gort_pkg;
  localparam int FRAC_BITS = 8;
  localparam int SIDE      = 64;
  localparam int CELL_AW   = 12;
  localparam logic [15:0] DIST_SAT = 16'hFFFF;
  localparam logic [8:0]  ONE_CELL = 9'd256;
  localparam logic [31:0] SQ_SAT   = 32'hFFFE0001;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_STAMP = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_RAY   = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAXD   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [6:0]  rh;
    logic [6:0]  rw;
    logic [15:0] id;
    logic        ny;
    logic        nx;
    logic        hy;
    logic        hx;
    logic [15:0] uy;
    logic [15:0] ux;
    logic [15:0] sy;
    logic [15:0] sx;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  width;
    logic [6:0]  height;
    logic [15:0] max_dist;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] id;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [15:0] hdist;
  } result_t;
endpackage
`default_nettype wire

[hw/rtl/gort_if.sv]
// Channel interfaces: input item word and result word with valid/ready.
// No dependencies.
`default_nettype none
interface gort_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [13:0] pos_y;
  logic [13:0] pos_x;
  logic [6:0]  rect_height;
  logic [6:0]  rect_width;
  logic [15:0] owner_id;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_x;
  modport source (output valid, operation, pos_y, pos_x, rect_height, rect_width, owner_id,
                  dir_y, dir_x, input ready);
  modport sink (input valid, operation, pos_y, pos_x, rect_height, rect_width, owner_id,
                dir_y, dir_x, output ready);
endinterface

interface gort_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] found_id;
  logic [5:0]  hit_row;
  logic [5:0]  hit_col;
  logic [15:0] hit_distance;
  modport source (output valid, hit, found_id, hit_row, hit_col, hit_distance, input ready);
  modport sink (input valid, hit, found_id, hit_row, hit_col, hit_distance, output ready);
endinterface
`default_nettype wire

[hw/rtl/gort_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module gort_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/gort_queue.sv]
// Two-entry command queue between front and back.
// Depends on gort_pkg.
`default_nettype none
module gort_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire gort_pkg::cmd_t push_data,
  input  wire logic          pop,
  output gort_pkg::cmd_t     head,
  output logic               full,
  output logic               empty
);
  import gort_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head  = slot_r[rp_r];
  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/gort_front.sv]
// Front end: accepts words, works out ray step lengths (divide, square root) and first edges.
// Depends on gort_pkg and gort_if.
`default_nettype none
module gort_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  gort_in_if.sink        in_chan,
  input  wire logic      init_done,
  input  wire logic      q_full,
  output logic           q_push,
  output gort_pkg::cmd_t q_data
);
  import gort_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0, F_AXIS = 3'd1, F_SQ = 3'd2, F_LOAD = 3'd3,
                         F_DIV = 3'd4, F_ROOT = 3'd5, F_EDGE = 3'd6, F_PUSH = 3'd7;

  logic [2:0]  st_r, st_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [15:0] my_r, my_nxt, mx_r, mx_nxt;
  logic [7:0]  fy_r, fy_nxt, fx_r, fx_nxt;
  logic        axis_r, axis_nxt;
  logic [31:0] aa_r, aa_nxt, oo_r, oo_nxt;
  logic [47:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] root_r, root_nxt;
  logic [3:0]  bit_r, bit_nxt;

  logic [15:0] along, other, t;
  logic [31:0] rem_s, tt;
  logic        ge, sat;
  logic [8:0]  party, partx;
  logic [24:0] pdy, pdx;

  assign in_chan.ready = (st_r == F_IDLE) && init_done;
  assign q_push = (st_r == F_PUSH) && !q_full;
  assign q_data = cmd_r;

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; my_nxt = my_r; mx_nxt = mx_r; fy_nxt = fy_r; fx_nxt = fx_r;
    axis_nxt = axis_r; aa_nxt = aa_r; oo_nxt = oo_r; num_nxt = num_r; quo_nxt = quo_r;
    rem_nxt = rem_r; cnt_nxt = cnt_r; root_nxt = root_r; bit_nxt = bit_r;
    along = axis_r ? mx_r : my_r;
    other = axis_r ? my_r : mx_r;
    rem_s = {rem_r[30:0], num_r[47]};
    ge    = rem_s >= aa_r;
    sat   = (quo_r[47:32] != 16'd0) || (quo_r[31:0] >= SQ_SAT);
    t     = root_r | (16'd1 << bit_r);
    tt    = t * t;
    party = cmd_r.ny ? {1'b0, fy_r} : ONE_CELL - {1'b0, fy_r};
    partx = cmd_r.nx ? {1'b0, fx_r} : ONE_CELL - {1'b0, fx_r};
    pdy   = party * cmd_r.uy;
    pdx   = partx * cmd_r.ux;
    case (st_r)
      F_IDLE: begin
        if (in_chan.valid && in_chan.ready) begin
          cmd_nxt.op  = in_chan.operation;
          cmd_nxt.row = in_chan.pos_y[13:8];
          cmd_nxt.col = in_chan.pos_x[13:8];
          cmd_nxt.rh  = in_chan.rect_height;
          cmd_nxt.rw  = in_chan.rect_width;
          cmd_nxt.id  = in_chan.owner_id;
          cmd_nxt.ny  = in_chan.dir_y[15];
          cmd_nxt.nx  = in_chan.dir_x[15];
          cmd_nxt.hy  = in_chan.dir_y != 16'sd0;
          cmd_nxt.hx  = in_chan.dir_x != 16'sd0;
          my_nxt = in_chan.dir_y[15] ? 16'(-in_chan.dir_y) : in_chan.dir_y;
          mx_nxt = in_chan.dir_x[15] ? 16'(-in_chan.dir_x) : in_chan.dir_x;
          fy_nxt = in_chan.pos_y[7:0];
          fx_nxt = in_chan.pos_x[7:0];
          axis_nxt = 1'b0;
          st_nxt = (in_chan.operation == OP_RAY) ? F_AXIS : F_PUSH;
        end
      end
      F_AXIS: begin
        if (axis_r ? cmd_r.hx : cmd_r.hy) begin
          st_nxt = F_SQ;
        end else begin
          if (axis_r) cmd_nxt.ux = 16'd0; else cmd_nxt.uy = 16'd0;
          axis_nxt = 1'b1;
          st_nxt = axis_r ? F_EDGE : F_AXIS;
        end
      end
      F_SQ: begin
        aa_nxt = along * along;
        oo_nxt = other * other;
        st_nxt = F_LOAD;
      end
      F_LOAD: begin
        num_nxt = {aa_r + oo_r, 16'd0};
        rem_nxt = 32'd0;
        quo_nxt = 48'd0;
        cnt_nxt = 6'd0;
        st_nxt  = F_DIV;
      end
      F_DIV: begin
        rem_nxt = ge ? rem_s - aa_r : rem_s;
        quo_nxt = {quo_r[46:0], ge};
        num_nxt = {num_r[46:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          root_nxt = 16'd0;
          bit_nxt  = 4'd15;
          st_nxt   = F_ROOT;
        end
      end
      F_ROOT: begin
        if (!sat && tt <= quo_r[31:0]) root_nxt = t;
        bit_nxt = bit_r - 4'd1;
        if (sat || bit_r == 4'd0) begin
          if (axis_r) cmd_nxt.ux = sat ? DIST_SAT : root_nxt;
          else        cmd_nxt.uy = sat ? DIST_SAT : root_nxt;
          axis_nxt = 1'b1;
          st_nxt = axis_r ? F_EDGE : F_AXIS;
        end
      end
      F_EDGE: begin
        cmd_nxt.sy = !cmd_r.hy ? DIST_SAT : (pdy[24] ? DIST_SAT : pdy[23:8]);
        cmd_nxt.sx = !cmd_r.hx ? DIST_SAT : (pdx[24] ? DIST_SAT : pdx[23:8]);
        st_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; my_r <= my_nxt; mx_r <= mx_nxt; fy_r <= fy_nxt; fx_r <= fx_nxt;
    axis_r <= axis_nxt; aa_r <= aa_nxt; oo_r <= oo_nxt; num_r <= num_nxt; quo_r <= quo_nxt;
    rem_r <= rem_nxt; cnt_r <= cnt_nxt; root_r <= root_nxt; bit_r <= bit_nxt;
  end
endmodule
`default_nettype wire

[hw/rtl/gort_back.sv]
// Back end: clear sweep, stamp, cell read and DDA walk over the cell RAM; result register.
// Depends on gort_pkg, gort_if and gort_ram.
`default_nettype none
module gort_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gort_pkg::cfg_t cfg,
  input  wire gort_pkg::cmd_t q_head,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                init_done,
  gort_out_if.source          out_chan
);
  import gort_pkg::*;

  localparam logic [2:0] B_CLEAR = 3'd0, B_IDLE = 3'd1, B_STRD = 3'd2, B_STWR = 3'd3,
                         B_RDWT = 3'd4, B_RSTEP = 3'd5, B_RTEST = 3'd6, B_EMIT = 3'd7;

  logic [2:0]         st_r, st_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CELL_AW-1:0] addr_r, addr_nxt;
  logic [6:0]         sr_r, sr_nxt, sc_r, sc_nxt;
  logic signed [10:0] rrow_r, rrow_nxt, rcol_r, rcol_nxt;
  logic [15:0]        sy_r, sy_nxt, sx_r, sx_nxt, dist_r, dist_nxt;
  logic               ingrid_r, ingrid_nxt;
  result_t            res_r, res_nxt, out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               init_r, init_nxt;

  logic [6:0]         wside, hside;
  logic [7:0]         srow, scol;
  logic               s_in;
  logic               stepx;
  logic signed [10:0] nrow, ncol;
  logic [16:0]        sum;
  logic               n_in, h_in;
  logic               ram_we;
  logic [CELL_AW-1:0] raddr;
  logic [15:0]        rdata, wdata;

  gort_ram #(.WIDTH(16), .DEPTH(SIDE * SIDE)) u_ram (
    .clk(clk), .we(ram_we), .waddr(addr_r), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign wside = (cfg.width == 7'd0) ? 7'd1 : ((cfg.width > 7'(SIDE)) ? 7'(SIDE) : cfg.width);
  assign hside = (cfg.height == 7'd0) ? 7'd1 :
                 ((cfg.height > 7'(SIDE)) ? 7'(SIDE) : cfg.height);

  assign init_done = init_r;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.hit          = out_r.hit;
  assign out_chan.found_id     = out_r.id;
  assign out_chan.hit_row      = out_r.row;
  assign out_chan.hit_col      = out_r.col;
  assign out_chan.hit_distance = out_r.hdist;

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; addr_nxt = addr_r; sr_nxt = sr_r; sc_nxt = sc_r;
    rrow_nxt = rrow_r; rcol_nxt = rcol_r; sy_nxt = sy_r; sx_nxt = sx_r; dist_nxt = dist_r;
    ingrid_nxt = ingrid_r; res_nxt = res_r; out_nxt = out_r; init_nxt = init_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    q_pop = 1'b0; ram_we = 1'b0; wdata = 16'd0; raddr = addr_r;
    srow  = {2'b00, cmd_r.row} + {1'b0, sr_r};
    scol  = {2'b00, cmd_r.col} + {1'b0, sc_r};
    s_in  = (srow < {1'b0, hside}) && (scol < {1'b0, wside});
    h_in  = (q_head.row < hside[5:0]) || (hside == 7'(SIDE));
    h_in  = h_in && ((q_head.col < wside[5:0]) || (wside == 7'(SIDE)));
    stepx = cmd_r.hx && (!cmd_r.hy || sx_r < sy_r);
    nrow  = rrow_r; ncol = rcol_r;
    if (stepx) ncol = cmd_r.nx ? rcol_r - 11'sd1 : rcol_r + 11'sd1;
    else       nrow = cmd_r.ny ? rrow_r - 11'sd1 : rrow_r + 11'sd1;
    sum   = stepx ? {1'b0, sx_r} + {1'b0, cmd_r.ux} : {1'b0, sy_r} + {1'b0, cmd_r.uy};
    n_in  = !nrow[10] && !ncol[10] && (nrow < $signed({4'b0, hside}))
            && (ncol < $signed({4'b0, wside}));
    case (st_r)
      B_CLEAR: begin
        ram_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (&addr_r) begin
          init_nxt = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        raddr = {q_head.row, q_head.col};
        if (!q_empty) begin
          q_pop = 1'b1;
          cmd_nxt = q_head;
          addr_nxt = '0;
          sr_nxt = 7'd0; sc_nxt = 7'd0;
          rrow_nxt = $signed({5'b0, q_head.row});
          rcol_nxt = $signed({5'b0, q_head.col});
          sy_nxt = q_head.sy; sx_nxt = q_head.sx; dist_nxt = 16'd0;
          ingrid_nxt = h_in;
          res_nxt = '0;
          case (q_head.op)
            OP_CLEAR: st_nxt = B_CLEAR;
            OP_STAMP: st_nxt = B_STRD;
            OP_READ:  st_nxt = B_RDWT;
            OP_RAY:   st_nxt = (!q_head.hy && !q_head.hx) ? B_EMIT : B_RSTEP;
            default:  st_nxt = B_IDLE;
          endcase
        end
      end
      B_STRD: begin
        raddr = {srow[5:0], scol[5:0]};
        addr_nxt = {srow[5:0], scol[5:0]};
        if (cmd_r.rh == 7'd0 || cmd_r.rw == 7'd0 || sr_r == cmd_r.rh) begin
          st_nxt = B_IDLE;
        end else begin
          if (s_in) st_nxt = B_STWR;
          if (sc_r + 7'd1 == cmd_r.rw) begin
            sc_nxt = 7'd0;
            sr_nxt = sr_r + 7'd1;
          end else begin
            sc_nxt = sc_r + 7'd1;
          end
        end
      end
      B_STWR: begin
        ram_we = rdata == 16'd0;
        wdata = cmd_r.id;
        st_nxt = B_STRD;
      end
      B_RDWT: begin
        res_nxt.id  = ingrid_r ? rdata : 16'd0;
        res_nxt.hit = ingrid_r && (rdata != 16'd0);
        res_nxt.row = cmd_r.row;
        res_nxt.col = cmd_r.col;
        st_nxt = B_EMIT;
      end
      B_RSTEP: begin
        raddr = {nrow[5:0], ncol[5:0]};
        if (dist_r >= cfg.max_dist) begin
          st_nxt = B_EMIT;
        end else begin
          rrow_nxt = nrow; rcol_nxt = ncol;
          dist_nxt = stepx ? sx_r : sy_r;
          if (stepx) sx_nxt = sum[16] ? DIST_SAT : sum[15:0];
          else       sy_nxt = sum[16] ? DIST_SAT : sum[15:0];
          ingrid_nxt = n_in;
          st_nxt = B_RTEST;
        end
      end
      B_RTEST: begin
        if (ingrid_r && rdata != 16'd0) begin
          res_nxt.hit = 1'b1;
          res_nxt.id = rdata;
          res_nxt.row = rrow_r[5:0];
          res_nxt.col = rcol_r[5:0];
          res_nxt.hdist = dist_r;
          st_nxt = B_EMIT;
        end else begin
          st_nxt = B_RSTEP;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLEAR;
      addr_r <= '0;
      out_valid_r <= 1'b0;
      init_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      addr_r <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      init_r <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; sr_r <= sr_nxt; sc_r <= sc_nxt; rrow_r <= rrow_nxt; rcol_r <= rcol_nxt;
    sy_r <= sy_nxt; sx_r <= sx_nxt; dist_r <= dist_nxt; ingrid_r <= ingrid_nxt;
    res_r <= res_nxt; out_r <= out_nxt;
  end
endmodule
`default_nettype wire

[hw/rtl/grid_occupancy_ray_traversal.sv]
// Top level: configuration registers, front end, command queue and back end.
// Depends on gort_pkg, gort_if, gort_front, gort_queue, gort_back.
//
//  channel   | dir | word
//  in_chan   | in  | operation, pos_y/x, rect_height/width, owner_id, dir_y/x
//  out_chan  | out | hit, found_id, hit_row, hit_col, hit_distance
//  cfg_*     | in  | cfg_we, cfg_index, cfg_wdata (no read-back)
//
// Read: one cell read, sent from B_EMIT. Stamp: each in-grid cell read in B_STRD, written in
// B_STWR if empty; out-of-grid cells skipped. Clear: one RAM word per cycle, all 4096 words.
// Ray: front setup (48-step divide, up to 16-step root per moving axis), then one RAM read per
// cell stepped. After reset a clearing pass runs; in_chan.ready stays low until it ends.
// Front and back overlap through a two-entry queue; the result register frees the back.
`default_nettype none
module grid_occupancy_ray_traversal (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gort_in_if.sink          in_chan,
  gort_out_if.source       out_chan,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import gort_pkg::*;

  cfg_t cfg_r;
  cmd_t q_in, q_head;
  logic q_push, q_pop, q_full, q_empty, init_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width    <= 7'd64;
      cfg_r.height   <= 7'd64;
      cfg_r.max_dist <= 16'd25600;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_r.width    <= cfg_wdata[6:0];
        REG_HEIGHT: cfg_r.height   <= cfg_wdata[6:0];
        REG_MAXD:   cfg_r.max_dist <= cfg_wdata;
        default: ;
      endcase
    end
  end

  gort_front u_front (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .init_done(init_done),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  gort_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  gort_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_head(q_head), .q_empty(q_empty),
    .q_pop(q_pop), .init_done(init_done), .out_chan(out_chan)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
    else $error("queue underflow");
  a_init_before_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> init_done) else $error("command taken before clearing pass ended");
`endif
endmodule
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for grid_occupancy_ray_traversal: directed table, then random words.
// Depends on gort_pkg, gort_if and the block's RTL; the grid, stamp and ray walk are predicted
// here.
`default_nettype none
module tb;
  import gort_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PHASE_WORDS    = 200;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [13:0]        pos_y;
    logic [13:0]        pos_x;
    logic [6:0]         rh;
    logic [6:0]         rw;
    logic [15:0]        id;
    logic signed [15:0] dy;
    logic signed [15:0] dx;
  } word_t;

  typedef struct packed {
    word_t   w;
    logic    typed;
    result_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  gort_in_if  in_chan ();
  gort_out_if out_chan ();

  grid_occupancy_ray_traversal dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [15:0] owner_grid [SIDE*SIDE];
  logic [6:0]  m_width, m_height;
  logic [15:0] m_maxd;
  result_t     pending_results [$];
  step_t       directed [$];
  int          src_idle, snk_idle;
  int          errors = 0;
  int          quiet_cycles = 0;

  function automatic int side_of(logic [6:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic bit in_grid(int row, int col);
    return row >= 0 && col >= 0 && row < side_of(m_height) && col < side_of(m_width);
  endfunction

  function automatic logic [15:0] unit_len(logic [31:0] along, logic [31:0] other);
    logic [63:0] l2, q, t;
    logic [31:0] r;
    l2 = 64'(along) * along + 64'(other) * other;
    q = (l2 << (2*FRAC_BITS)) / (64'(along) * along);
    if (q >= 64'(65535) * 65535) return DIST_SAT;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = 64'(r | (32'd1 << b));
      if (t * t <= q) r = t[31:0];
    end
    return r[15:0];
  endfunction

  function automatic logic [15:0] edge_len(logic [13:0] pos, bit neg, logic [15:0] u);
    logic [31:0] part;
    logic [63:0] d;
    part = neg ? pos[7:0] : 32'd256 - pos[7:0];
    d = (64'(part) * u) >> FRAC_BITS;
    return d > 64'(DIST_SAT) ? DIST_SAT : d[15:0];
  endfunction

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = a + b;
    return s[16] ? DIST_SAT : s[15:0];
  endfunction

  function automatic result_t walk_ray(word_t w);
    result_t res;
    bit ny, nx, hy, hx;
    logic [31:0] my, mx;
    logic [15:0] uy, ux, sy, sx, ray_len;
    int row, col;
    res = '0;
    ny = w.dy[15];
    nx = w.dx[15];
    my = ny ? 32'd65536 - 32'(w.dy[15:0]) : 32'(w.dy[15:0]);
    mx = nx ? 32'd65536 - 32'(w.dx[15:0]) : 32'(w.dx[15:0]);
    hy = my != 0;
    hx = mx != 0;
    row = w.pos_y[13:8];
    col = w.pos_x[13:8];
    uy = hy ? unit_len(my, mx) : 16'd0;
    ux = hx ? unit_len(mx, my) : 16'd0;
    sy = hy ? edge_len(w.pos_y, ny, uy) : DIST_SAT;
    sx = hx ? edge_len(w.pos_x, nx, ux) : DIST_SAT;
    ray_len = 0;
    if (!hy && !hx) return res;
    while (ray_len < m_maxd) begin
      if (hx && (!hy || sx < sy)) begin
        col += nx ? -1 : 1;
        ray_len = sx;
        sx = sat_sum(sx, ux);
      end else begin
        row += ny ? -1 : 1;
        ray_len = sy;
        sy = sat_sum(sy, uy);
      end
      if (in_grid(row, col) && owner_grid[row*SIDE+col] != 0) begin
        res.hit = 1'b1;
        res.id = owner_grid[row*SIDE+col];
        res.row = row[5:0];
        res.col = col[5:0];
        res.hdist = ray_len;
        return res;
      end
    end
    return res;
  endfunction

  // applies one accepted word to the grid; returns 1 when a result word follows
  function automatic bit predict_word(word_t w, output result_t res);
    int row, col;
    row = w.pos_y[13:8];
    col = w.pos_x[13:8];
    res = '0;
    case (w.op)
      OP_CLEAR: begin
        foreach (owner_grid[i]) owner_grid[i] = '0;
        return 0;
      end
      OP_STAMP: begin
        for (int r = 0; r < w.rh; r++)
          for (int c = 0; c < w.rw; c++)
            if (in_grid(row + r, col + c) && owner_grid[(row+r)*SIDE+col+c] == 0)
              owner_grid[(row+r)*SIDE+col+c] = w.id;
        return 0;
      end
      OP_READ: begin
        res.id = in_grid(row, col) ? owner_grid[row*SIDE+col] : 16'd0;
        res.hit = res.id != 0;
        res.row = row[5:0];
        res.col = col[5:0];
        return 1;
      end
      default: begin
        res = walk_ray(w);
        return 1;
      end
    endcase
  endfunction

  task automatic send(step_t s);
    result_t res;
    while ($urandom_range(99) < src_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.operation <= s.w.op;
    in_chan.pos_y <= s.w.pos_y;
    in_chan.pos_x <= s.w.pos_x;
    in_chan.rect_height <= s.w.rh;
    in_chan.rect_width <= s.w.rw;
    in_chan.owner_id <= s.w.id;
    in_chan.dir_y <= s.w.dy;
    in_chan.dir_x <= s.w.dx;
    in_chan.valid <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    if (predict_word(s.w, res))
      pending_results.insert(pending_results.size(), s.typed ? s.want : res);
  endtask

  // caller lowers cfg_we after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  m_width = val[6:0];
      REG_HEIGHT: m_height = val[6:0];
      REG_MAXD:   m_maxd = val;
      default: ;
    endcase
  endtask

  // sender holds off until every result is back; a trailing read completes after any
  // earlier stamp or clear, as words are carried out in order
  task automatic drain();
    step_t s;
    s = '0;
    s.w.op = OP_READ;
    send(s);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(step_t s);
    directed.insert(directed.size(), s);
  endfunction

  function automatic step_t row_of(logic [1:0] op, logic [13:0] py, logic [13:0] px,
                                   logic [6:0] rh, logic [6:0] rw, logic [15:0] id,
                                   logic [15:0] dy, logic [15:0] dx,
                                   logic typed, result_t want);
    step_t s;
    s.w = '{op, py, px, rh, rw, id, dy, dx};
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic step_t random_step();
    step_t s;
    int sel, rr, cc;
    s = '0;
    sel = $urandom_range(99);
    s.w.op = sel < 2 ? OP_CLEAR : sel < 32 ? OP_STAMP : sel < 57 ? OP_READ : OP_RAY;
    rr = $urandom_range(0, side_of(m_height) + 1);
    cc = $urandom_range(0, side_of(m_width) + 1);
    s.w.pos_y = {rr[5:0], 8'($urandom)};
    s.w.pos_x = {cc[5:0], 8'($urandom)};
    if ($urandom_range(9) == 0) s.w.pos_y = 14'($urandom);
    if ($urandom_range(9) == 0) s.w.pos_x = 14'($urandom);
    s.w.rh = $urandom_range(32) == 0 ? 7'($urandom) : 7'($urandom_range(0, 6));
    s.w.rw = $urandom_range(32) == 0 ? 7'($urandom) : 7'($urandom_range(0, 6));
    sel = $urandom_range(19);
    s.w.id = sel == 0 ? 16'd0 : sel == 1 ? 16'hFFFF : 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 30) begin
      s.w.dy = 16'($signed($urandom_range(0, 16)) - 8);
      s.w.dx = 16'($signed($urandom_range(0, 16)) - 8);
    end else begin
      s.w.dy = 16'($urandom);
      s.w.dx = 16'($urandom);
    end
    if (sel >= 90) s.w.dy = '0;
    else if (sel >= 80) s.w.dx = '0;
    if (sel == 99) s.w.dx = '0;
    return s;
  endfunction

  // receiver
  always @(posedge clk) begin
    out_chan.ready <= $urandom_range(99) >= snk_idle;
  end

  task automatic report(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual id %0d", $time,
                 out_chan.found_id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        report("hit", want.hit, out_chan.hit);
        report("found_id", want.id, out_chan.found_id);
        report("hit_row", want.row, out_chan.hit_row);
        report("hit_col", want.col, out_chan.hit_col);
        report("hit_distance", want.hdist, out_chan.hit_distance);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("grid_occupancy_ray_traversal regression: fail");
      $finish;
    end
  end

  initial begin
    result_t none;
    none = '0;
    in_chan.valid = 1'b0;
    in_chan.operation = OP_CLEAR;
    in_chan.pos_y = '0;
    in_chan.pos_x = '0;
    in_chan.rect_height = '0;
    in_chan.rect_width = '0;
    in_chan.owner_id = '0;
    in_chan.dir_y = '0;
    in_chan.dir_x = '0;
    out_chan.ready = 1'b0;
    foreach (owner_grid[i]) owner_grid[i] = '0;
    m_width = 7'd64;
    m_height = 7'd64;
    m_maxd = 16'd25600;
    src_idle = 12;
    snk_idle = 63;

    add_row(row_of(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, none));
    add_row(row_of(OP_READ, 14'h3FFF, 14'h3FFF, 0, 0, 0, 0, 0, 1,
                   '{1'b0, 16'd0, 6'd63, 6'd63, 16'd0}));
    add_row(row_of(OP_STAMP, 0, 0, 1, 1, 5, 0, 0, 0, none));
    add_row(row_of(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b1, 16'd5, 6'd0, 6'd0, 16'd0}));
    add_row(row_of(OP_STAMP, 0, 0, 2, 2, 7, 0, 0, 0, none));
    add_row(row_of(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, '{1'b1, 16'd5, 6'd0, 6'd0, 16'd0}));
    add_row(row_of(OP_READ, 14'h100, 14'h100, 0, 0, 0, 0, 0, 1,
                   '{1'b1, 16'd7, 6'd1, 6'd1, 16'd0}));
    add_row(row_of(OP_STAMP, 14'h0A00, 14'h0A00, 1, 1, 0, 0, 0, 0, none));
    add_row(row_of(OP_READ, 14'h0A00, 14'h0A00, 0, 0, 0, 0, 0, 1,
                   '{1'b0, 16'd0, 6'd10, 6'd10, 16'd0}));
    add_row(row_of(OP_STAMP, 14'h1400, 0, 1, 64, 16'hFFFF, 0, 0, 0, none));
    add_row(row_of(OP_RAY, 14'h0580, 14'h0580, 0, 0, 0, 1, 0, 1,
                   '{1'b1, 16'hFFFF, 6'd20, 6'd5, 16'd3712}));
    add_row(row_of(OP_RAY, 14'h0580, 14'h0580, 0, 0, 0, 0, 0, 1, none));
    add_row(row_of(OP_RAY, 14'h1480, 14'h0580, 0, 0, 0, 16'h8000, 16'h7FFF, 0, none));
    add_row(row_of(OP_RAY, 14'h3FFF, 14'h3FFF, 0, 0, 0, 16'hFFFF, 16'h8000, 0, none));
    add_row(row_of(OP_RAY, 14'h0A80, 14'h0A80, 0, 0, 0, 16'h7FFF, 16'h0001, 0, none));
    add_row(row_of(OP_STAMP, 14'h3F00, 14'h3F00, 64, 64, 16'h1234, 0, 0, 0, none));
    add_row(row_of(OP_STAMP, 14'h0300, 14'h0300, 0, 5, 16'h0042, 0, 0, 0, none));
    add_row(row_of(OP_STAMP, 14'h1E00, 14'h1E00, 1, 1, 9, 0, 0, 0, none));
    add_row(row_of(OP_RAY, 14'h1E80, 14'h1E80, 0, 0, 0, 0, 1, 0, none));
    add_row(row_of(OP_RAY, 14'h1E80, 14'h1D80, 0, 0, 0, 0, 1, 0, none));
    add_row(row_of(OP_READ, 14'h3F00, 14'h3F00, 0, 0, 0, 0, 0, 0, none));
    add_row(row_of(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, none));
    add_row(row_of(OP_READ, 14'h100, 14'h100, 0, 0, 0, 0, 0, 1,
                   '{1'b0, 16'd0, 6'd1, 6'd1, 16'd0}));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send(directed[i]);

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(REG_WIDTH, 16'd0);
          write_reg(REG_HEIGHT, 16'd0);
          write_reg(REG_MAXD, 16'd0);
        end
        1: begin
          write_reg(REG_WIDTH, 16'd127);
          write_reg(REG_HEIGHT, 16'd127);
          write_reg(REG_MAXD, 16'hFFFF);
        end
        2: begin
          write_reg(REG_WIDTH, 16'd17);
          write_reg(REG_HEIGHT, 16'd40);
          write_reg(REG_MAXD, 16'd3000);
          write_reg(REG_UNUSED, 16'($urandom));
        end
        3: begin
          write_reg(REG_WIDTH, 16'd64);
          write_reg(REG_HEIGHT, 16'd5);
          write_reg(REG_MAXD, 16'd25600);
        end
        default: begin
          write_reg(REG_WIDTH, 16'd1);
          write_reg(REG_HEIGHT, 16'd64);
          write_reg(REG_MAXD, 16'($urandom));
        end
      endcase
      cfg_we <= 1'b0;
      src_idle = p < 2 ? 12 : p < 4 ? 63 : 0;
      snk_idle = p < 2 ? 63 : p < 4 ? 12 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) send(random_step());
    end

    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("grid_occupancy_ray_traversal regression: pass");
    else
      $display("grid_occupancy_ray_traversal regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
